>>> sv/ggc_pkg.sv
// Shared constants, payload types and bit-search helpers for the greedy graph coloring block.
`timescale 1ns / 1ps
`default_nettype none

package ggc_pkg;

    localparam int MAX_NODES   = 64;
    // Vertex indices are 6 bits wide, so never more than 64 vertices in use.
    localparam int NODE_LIM    = (MAX_NODES < 64) ? MAX_NODES : 64;
    localparam int NODE_W      = $clog2(NODE_LIM);
    localparam int VTX_W       = 6;
    localparam int COLOR_W     = 6;
    localparam int NUM_COLORS  = 64;
    localparam int COUNT_W     = 7;
    localparam int COUNT_RESET = 64;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] OP_EDGE  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_RUN   = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [VTX_W-1:0] node_a;
        logic [VTX_W-1:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic [VTX_W-1:0]   vertex;
        logic [COLOR_W-1:0] color;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_EDGE,
        CMD_CLEAR,
        CMD_RUN
    } cmd_kind_t;

    // Edge: row is the higher endpoint, col the lower one.
    // Run: row is the index of the last vertex to color.
    typedef struct packed {
        cmd_kind_t         kind;
        logic [NODE_W-1:0] row;
        logic [NODE_W-1:0] col;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Index of the lowest set bit; zero when none is set.
    function automatic logic [NODE_W-1:0] lowest_index(input logic [NODE_LIM-1:0] x);
        logic [NODE_LIM-1:0] onehot;
        logic [NODE_W-1:0]   idx;
        onehot = x & (~x + 1'b1);
        idx    = '0;
        for (int i = 0; i < NODE_LIM; i++) begin
            if (onehot[i])
            begin
                idx = idx | NODE_W'(i);
            end
        end
        return idx;
    endfunction

    // Smallest color not in the set, held to the top color when all lower ones are taken.
    function automatic logic [COLOR_W-1:0] first_free_color(input logic [NUM_COLORS-1:0] used);
        logic [NUM_COLORS-1:0] free;
        logic [NUM_COLORS-1:0] onehot;
        logic [COLOR_W-1:0]    idx;
        free                 = ~used;
        free[NUM_COLORS-1]   = 1'b1;
        onehot               = free & (~free + 1'b1);
        idx                  = '0;
        for (int i = 0; i < NUM_COLORS; i++) begin
            if (onehot[i])
            begin
                idx = idx | COLOR_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> sv/greedy_graph_coloring.sv
// Top level of the first-fit greedy graph coloring block.
//
//  channel   | handshake              | payload              | notes
//  ----------+------------------------+----------------------+---------------------------
//  request   | start, busy            | request (in_item_t)  | taken when start && !busy
//  result    | done                   | result (out_item_t)  | one-cycle strobe, no stall
//  config    | cfg_we                 | cfg_data (7 bits)    | node_count, write only
//
// Steps: an edge transaction is a pop, a row read and a row write; a clear is a pop alone.
// A run is a pop, then per vertex a row read, a row load, a neighbor-color gather over its
// lower-numbered neighbors and a pick; the gather reads one color memory entry a cycle.
// Transactions queue in a 4-entry command queue; busy is high only while it is full.
// Reset: rst_n clears the queue, engine state and all adjacency row valid bits at once
// (the graph is empty right after reset, no clearing pass), and sets node_count to 64.
// The result receiver cannot stall; each result appears on done for exactly one cycle.

`timescale 1ns / 1ps
`default_nettype none

module greedy_graph_coloring
    import ggc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire in_item_t           request,
    output logic                    done,
    output out_item_t               result,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_data
);

    // Front end to queue
    logic      push;
    cmd_t      push_cmd;
    // Queue to engine
    logic      pop;
    cmd_t      head;
    q_status_t q_stat;

    ggc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .request  (request),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_stat   (q_stat),
        .busy     (busy),
        .push     (push),
        .push_cmd (push_cmd)
    );

    ggc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    ggc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

`default_nettype wire

>>> sv/ggc_front.sv
// Front end: node count register, transaction accept and command classification.
`timescale 1ns / 1ps
`default_nettype none

module ggc_front
    import ggc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire in_item_t           request,
    input  wire logic               cfg_we,
    input  wire logic [COUNT_W-1:0] cfg_data,
    input  wire q_status_t          q_stat,
    output logic                    busy,
    output logic                    push,
    output cmd_t                    push_cmd
);

    logic [COUNT_W-1:0] node_count_reg;
    logic [COUNT_W-1:0] lim;
    logic [COUNT_W-1:0] a_ext;
    logic [COUNT_W-1:0] b_ext;
    logic               edge_ok;
    logic               keep;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            node_count_reg <= COUNT_W'(COUNT_RESET);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_data;
        end
    end

    assign lim   = (node_count_reg > COUNT_W'(NODE_LIM)) ? COUNT_W'(NODE_LIM) : node_count_reg;
    assign a_ext = COUNT_W'(request.node_a);
    assign b_ext = COUNT_W'(request.node_b);
    assign edge_ok = (a_ext < lim) && (b_ext < lim) && (request.node_a != request.node_b);

    always_comb begin
        keep          = 1'b0;
        push_cmd.kind = CMD_EDGE;
        push_cmd.row  = '0;
        push_cmd.col  = '0;
        case (request.opcode)
            OP_EDGE:
            begin
                keep = edge_ok;
                // Only the lower triangle is kept: row holds the higher endpoint.
                if (request.node_a > request.node_b)
                begin
                    push_cmd.row = request.node_a[NODE_W-1:0];
                    push_cmd.col = request.node_b[NODE_W-1:0];
                end
                else
                begin
                    push_cmd.row = request.node_b[NODE_W-1:0];
                    push_cmd.col = request.node_a[NODE_W-1:0];
                end
            end
            OP_CLEAR:
            begin
                keep          = 1'b1;
                push_cmd.kind = CMD_CLEAR;
            end
            OP_RUN:
            begin
                keep          = (lim != '0);
                push_cmd.kind = CMD_RUN;
                push_cmd.row  = NODE_W'(lim - 1'b1);
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign busy = q_stat.full;
    assign push = start && !busy && keep;

endmodule

`default_nettype wire

>>> sv/ggc_queue.sv
// Short command queue between the front end and the execution engine.
`timescale 1ns / 1ps
`default_nettype none

module ggc_queue
    import ggc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output cmd_t      head,
    output q_status_t stat
);

    cmd_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    always_ff @(posedge clk) begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_comb begin
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    assign head       = entries_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

>>> sv/ggc_back.sv
// Execution engine: adjacency and color memories, edge store, clear and coloring sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ggc_back
    import ggc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire q_status_t q_stat,
    input  wire cmd_t      head,
    output logic           pop,
    output logic           done,
    output out_item_t      result
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_EDGE_RD = 7'b0000010,
        S_EDGE_WR = 7'b0000100,
        S_ROW_RD  = 7'b0001000,
        S_ROW_LD  = 7'b0010000,
        S_GATHER  = 7'b0100000,
        S_PICK    = 7'b1000000
    } state_t;

    state_t                state_reg,     state_next;
    logic [NODE_W-1:0]     row_reg,       row_next;
    logic [NODE_W-1:0]     col_reg,       col_next;
    logic [NODE_W-1:0]     u_reg,         u_next;
    logic [NODE_LIM-1:0]   nb_reg,        nb_next;
    logic [NUM_COLORS-1:0] used_reg,      used_next;
    logic                  pend_reg,      pend_next;
    logic [NODE_LIM-1:0]   row_valid_reg, row_valid_next;
    out_item_t             res_reg,       res_next;
    logic                  res_valid_reg, res_valid_next;

    logic [NODE_LIM-1:0] adj_mem [NODE_LIM];
    logic [NODE_LIM-1:0] adj_q_reg;
    logic [NODE_W-1:0]   adj_raddr;
    logic                adj_we;
    logic [NODE_LIM-1:0] adj_wdata;
    logic [NODE_LIM-1:0] adj_row;

    logic [COLOR_W-1:0]  color_mem [NODE_LIM];
    logic [COLOR_W-1:0]  col_q_reg;
    logic [NODE_W-1:0]   color_raddr;
    logic                color_we;
    logic [COLOR_W-1:0]  pick_color;
    logic [NODE_LIM-1:0] below;

    // A row whose valid bit is clear reads as empty.
    assign adj_row     = row_valid_reg[row_reg] ? adj_q_reg : '0;
    assign adj_wdata   = adj_row | (NODE_LIM'(1) << col_reg);
    assign adj_raddr   = (state_reg == S_ROW_RD) ? u_reg : row_reg;
    assign color_raddr = lowest_index(nb_reg);
    assign pick_color  = first_free_color(used_reg);
    assign below       = (NODE_LIM'(1) << u_reg) - 1'b1;

    always_ff @(posedge clk) begin
        if (adj_we)
        begin
            adj_mem[row_reg] <= adj_wdata;
        end
        adj_q_reg <= adj_mem[adj_raddr];
    end

    always_ff @(posedge clk) begin
        if (color_we)
        begin
            color_mem[u_reg] <= pick_color;
        end
        col_q_reg <= color_mem[color_raddr];
    end

    always_comb begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        u_next         = u_reg;
        nb_next        = nb_reg;
        used_next      = used_reg;
        pend_next      = pend_reg;
        row_valid_next = row_valid_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        pop            = 1'b0;
        adj_we         = 1'b0;
        color_we       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop      = 1'b1;
                    row_next = head.row;
                    col_next = head.col;
                    case (head.kind)
                        CMD_EDGE:
                        begin
                            state_next = S_EDGE_RD;
                        end
                        CMD_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        CMD_RUN:
                        begin
                            u_next     = '0;
                            state_next = S_ROW_RD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDGE_RD:
            begin
                state_next = S_EDGE_WR;
            end
            S_EDGE_WR:
            begin
                adj_we                  = 1'b1;
                row_valid_next[row_reg] = 1'b1;
                state_next              = S_IDLE;
            end
            S_ROW_RD:
            begin
                state_next = S_ROW_LD;
            end
            S_ROW_LD:
            begin
                nb_next    = (row_valid_reg[u_reg] ? adj_q_reg : '0) & below;
                used_next  = '0;
                pend_next  = 1'b0;
                state_next = S_GATHER;
            end
            S_GATHER:
            begin
                // One neighbor color read issued per cycle, merged from the registered data in the cycle after.
                if (nb_reg != '0)
                begin
                    nb_next   = nb_reg & (nb_reg - 1'b1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    used_next = used_reg | (NUM_COLORS'(1) << col_q_reg);
                end
                if ((nb_reg == '0) && !pend_reg)
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                color_we       = 1'b1;
                res_valid_next = 1'b1;
                res_next.vertex = VTX_W'(u_reg);
                res_next.color  = pick_color;
                res_next.last   = (u_reg == row_reg);
                if (u_reg == row_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    u_next     = u_reg + 1'b1;
                    state_next = S_ROW_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            row_valid_reg <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            row_valid_reg <= row_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk) begin
        row_reg  <= row_next;
        col_reg  <= col_next;
        u_reg    <= u_next;
        nb_reg   <= nb_next;
        used_reg <= used_next;
        res_reg  <= res_next;
    end

    assign done   = res_valid_reg;
    assign result = res_reg;

    a_strobe_from_pick: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> $past(state_reg == S_PICK))
        else $error("result strobe without a preceding pick cycle");

    a_gather_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GATHER) && (nb_reg == '0) && !pend_reg |=> (state_reg == S_PICK))
        else $error("gather finished but no pick followed");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.last |-> (state_reg == S_IDLE))
        else $error("engine still running after the last result");

    a_edge_marks_row: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDGE_WR) |=> row_valid_reg[$past(row_reg)])
        else $error("stored row not marked valid");

endmodule

`default_nettype wire

>>> dv/greedy_graph_coloring_checker.sv
// Transaction monitor, coloring predictor and result scoreboard for greedy_graph_coloring.
`timescale 1ns / 1ps

module greedy_graph_coloring_checker
    import ggc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  in_item_t           request,
    input  logic               done,
    input  out_item_t          result,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 colors_pending,
    output int                 items_taken,
    output int                 colors_checked
);

    logic [NODE_LIM-1:0] adj_rows [NODE_LIM];
    logic [COLOR_W-1:0]  color_of [NODE_LIM];
    logic [COUNT_W-1:0]  vtx_count;
    out_item_t           color_q [$];

    // Vertices in use: the register, capped by the matrix size.
    function automatic int active_vertices();
        int n;
        n = vtx_count;
        if (n > NODE_LIM)
        begin
            n = NODE_LIM;
        end
        return n;
    endfunction

    // First-fit coloring of vertices 0..n-1; queues one expected result per vertex.
    task automatic color_graph();
        int                  n;
        int                  c;
        logic [NODE_LIM-1:0] earlier;
        logic [NUM_COLORS-1:0] taken;
        out_item_t           r;
        n = active_vertices();
        for (int u = 0; u < n; u++)
        begin
            earlier = adj_rows[u] & ((NODE_LIM'(1) << u) - 1'b1);
            taken   = '0;
            for (int v = 0; v < u; v++)
            begin
                if (earlier[v])
                begin
                    taken[color_of[v]] = 1'b1;
                end
            end
            c = 0;
            while (c < NUM_COLORS - 1 && taken[c])
            begin
                c++;
            end
            color_of[u] = COLOR_W'(c);
            r.vertex    = VTX_W'(u);
            r.color     = COLOR_W'(c);
            r.last      = (u == n - 1);
            color_q     = {color_q, r};
        end
    endtask

    task automatic apply_request(input in_item_t req);
        int n;
        n = active_vertices();
        case (req.opcode)
            OP_EDGE:
            begin
                if (req.node_a < n && req.node_b < n && req.node_a != req.node_b)
                begin
                    adj_rows[req.node_a][req.node_b] = 1'b1;
                    adj_rows[req.node_b][req.node_a] = 1'b1;
                end
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NODE_LIM; i++)
                begin
                    adj_rows[i] = '0;
                end
            end
            OP_RUN:
            begin
                color_graph();
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NODE_LIM; i++)
            begin
                adj_rows[i] = '0;
                color_of[i] = '0;
            end
            vtx_count      = COUNT_W'(COUNT_RESET);
            color_q.delete();
            fail_count     = 0;
            items_taken    = 0;
            colors_checked = 0;
            colors_pending = 0;
        end
        else
        begin
            // results first: none can stem from a transaction taken at this same edge
            if (done)
            begin
                if (color_q.size() == 0)
                begin
                    $error("unexpected result: vertex %0d color %0d last %0d",
                           result.vertex, result.color, result.last);
                    fail_count++;
                end
                else
                begin
                    want = color_q.pop_front();
                    colors_checked++;
                    if (result.vertex !== want.vertex)
                    begin
                        $error("vertex: expected %0d, actual %0d", want.vertex, result.vertex);
                        fail_count++;
                    end
                    if (result.color !== want.color)
                    begin
                        $error("color: expected %0d, actual %0d", want.color, result.color);
                        fail_count++;
                    end
                    if (result.last !== want.last)
                    begin
                        $error("last: expected %0d, actual %0d", want.last, result.last);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                vtx_count = cfg_data;
            end
            if (start && !busy)
            begin
                items_taken++;
                apply_request(request);
            end
            colors_pending = color_q.size();
        end
    end

endmodule

>>> dv/greedy_graph_coloring_test.sv
// Top of the greedy_graph_coloring testbench: clock, reset, stimulus and final verdict.
`timescale 1ns / 1ps

module greedy_graph_coloring_test;
    import ggc_pkg::*;

    // Opcode the block ignores; only this file issues it.
    localparam logic [1:0] OP_NOP = 2'd3;
    // Generous limit: many runs over the full 64 vertices, plus idle gaps.
    localparam int CYCLE_LIMIT = 3_000_000;
    // Engine drain after the last result: a full queue of edge transactions, with margin.
    localparam int DRAIN_CYCLES = 60;
    localparam int ITEM_TARGET = 155;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               start;
    logic               busy;
    in_item_t           request;
    logic               done;
    out_item_t          result;
    logic               cfg_we;
    logic [COUNT_W-1:0] cfg_data;

    int fail_count;
    int colors_pending;
    int items_taken;
    int colors_checked;

    int cycle_count = 0;
    int graph_items = 0;  // transactions that change or read the graph
    int run_count = 0;
    int setting_count = 0;
    bit no_idle = 1'b0;   // when set, transactions go back to back

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    greedy_graph_coloring i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    greedy_graph_coloring_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .request        (request),
        .done           (done),
        .result         (result),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .colors_pending (colors_pending),
        .items_taken    (items_taken),
        .colors_checked (colors_checked)
    );

    // Watchdog: a hung handshake or a lost result ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("greedy_graph_coloring verification failed");
            $finish;
        end
    end

    // Issue one transaction. Called and returns at a falling edge; start stays high
    // across back-to-back transactions so it is never dropped and raised in one step.
    task automatic send_txn(input logic [1:0] op, input int a, input int b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start          = 1'b1;
        request.opcode = op;
        request.node_a = VTX_W'(a);
        request.node_b = VTX_W'(b);
        do
        begin
            @(posedge clk);
        end
        while (busy);
        @(negedge clk);
        if (op == OP_RUN)
        begin
            run_count++;
        end
        if (op != OP_NOP)
        begin
            graph_items++;
        end
    endtask

    // Quiesce: all expected colors back, then let queued edge/clear work drain.
    task automatic wait_quiet();
        start = 1'b0;
        while (colors_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // node_count write; only called after wait_quiet.
    task automatic set_node_count(input int value);
        cfg_we   = 1'b1;
        cfg_data = COUNT_W'(value);
        @(negedge clk);
        cfg_we   = 1'b0;
        setting_count++;
    endtask

    // One random graph: pick a size, maybe clear, add edges, color it.
    task automatic random_graph();
        int pick;
        int n;
        int span;
        int num_edges;
        int a;
        int b;
        int kind;
        int prev_a;
        int prev_b;
        pick = $urandom_range(0, 19);
        if (pick == 0)
        begin
            n = 64;
        end
        else if (pick == 1)
        begin
            n = 0;
        end
        else if (pick == 2)
        begin
            n = $urandom_range(65, 127);
        end
        else if (pick == 3)
        begin
            n = 1;
        end
        else if (pick == 4)
        begin
            n = 2;
        end
        else
        begin
            n = $urandom_range(3, 16);
        end
        wait_quiet();
        set_node_count(n);
        no_idle = ($urandom_range(0, 3) == 0);
        span = (n > 64) ? 64 : n;
        // leaving old edges in place exercises stale rows after a size change
        if ($urandom_range(0, 1) == 0)
        begin
            send_txn(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
        end
        num_edges = (span < 2) ? $urandom_range(0, 3) : $urandom_range(1, 2 * span + 4);
        if (num_edges > 30)
        begin
            num_edges = 30;
        end
        prev_a = 0;
        prev_b = 1;
        for (int i = 0; i < num_edges; i++)
        begin
            kind = $urandom_range(0, 19);
            if (kind == 0)
            begin
                send_txn(OP_NOP, $urandom_range(0, 63), $urandom_range(0, 63));
            end
            else if (kind <= 2)
            begin
                // any endpoints: out-of-range and self-loop cases
                send_txn(OP_EDGE, $urandom_range(0, 63), $urandom_range(0, 63));
            end
            else if (kind == 3)
            begin
                send_txn(OP_EDGE, prev_b, prev_a);
            end
            else
            begin
                a = (span == 0) ? 0 : $urandom_range(0, span - 1);
                b = (span == 0) ? 0 : $urandom_range(0, span - 1);
                send_txn(OP_EDGE, a, b);
                prev_a = a;
                prev_b = b;
            end
        end
        send_txn(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
        if ($urandom_range(0, 4) == 0)
        begin
            // second run on the same graph must repeat the coloring
            send_txn(OP_RUN, 0, 0);
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        request  = '0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: default size of 64, empty graph first.
        send_txn(OP_RUN, 0, 0);
        send_txn(OP_EDGE, 0, 63);
        send_txn(OP_EDGE, 63, 0);      // duplicate
        send_txn(OP_EDGE, 5, 5);       // self-loop
        send_txn(OP_EDGE, 1, 2);
        send_txn(OP_EDGE, 2, 3);
        send_txn(OP_EDGE, 3, 1);       // triangle needs three colors
        send_txn(OP_NOP, 63, 63);
        send_txn(OP_RUN, 0, 0);

        // zero vertices: edge ignored, run emits nothing
        wait_quiet();
        set_node_count(0);
        send_txn(OP_EDGE, 1, 2);
        send_txn(OP_RUN, 0, 0);

        wait_quiet();
        set_node_count(1);
        send_txn(OP_RUN, 0, 0);

        // register above the matrix size clamps to 64
        wait_quiet();
        set_node_count(127);
        send_txn(OP_EDGE, 62, 63);
        send_txn(OP_EDGE, 42, 21);
        send_txn(OP_RUN, 0, 0);

        // shrink with stale edges stored, out-of-range endpoint ignored
        wait_quiet();
        set_node_count(4);
        send_txn(OP_EDGE, 0, 4);
        send_txn(OP_EDGE, 0, 1);
        send_txn(OP_RUN, 0, 0);
        send_txn(OP_CLEAR, 0, 0);
        send_txn(OP_RUN, 0, 0);

        while (graph_items < ITEM_TARGET)
        begin
            random_graph();
        end

        // End of test: everything expected must arrive, then let the engine settle.
        start = 1'b0;
        while (colors_pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Covered %0d transactions and %0d coloring runs over %0d node_count settings;",
                 items_taken, run_count, setting_count);
        $display("%0d vertex colors compared, %0d mismatches.", colors_checked, fail_count);
        if (fail_count == 0)
        begin
            $display("greedy_graph_coloring verification clean");
        end
        else
        begin
            $display("greedy_graph_coloring verification failed");
        end
        $finish;
    end

endmodule
